### hw/rtl/smle_pkg.sv
// ----------------------------------------------------------------------------
// smle_pkg
// shared constants and types of the lognormal moment estimator
// ----------------------------------------------------------------------------
package smle_pkg;

  localparam int MAX_SAMPLES    = 4096;
  localparam int LOG_ITERATIONS = 24;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IT_W   = $clog2(LOG_ITERATIONS + 1);
  localparam int SUM_W  = 44;
  localparam int LOG_W  = 39;
  localparam int T_W    = 44;
  localparam int FB_W   = 6;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [FB_W-1:0] FB_SUM   = 6'd16;
  localparam logic [FB_W-1:0] FB_SQ    = 6'd32;
  localparam logic [FB_W-1:0] FB_COUNT = 6'd0;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

### hw/rtl/smle_mul.sv
// ----------------------------------------------------------------------------
// smle_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module smle_mul (
  input  logic              clk,
  input  smle_pkg::mul_req_t req,
  output logic [63:0]       prod
);
  import smle_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule

### hw/rtl/smle_div.sv
// ----------------------------------------------------------------------------
// smle_div
// restoring divider, one quotient bit per cycle, 64-bit dividend
// ----------------------------------------------------------------------------
module smle_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                dividend,
  input  logic [smle_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [63:0]                quotient
);
  import smle_pkg::*;

  logic             run;
  logic [5:0]       cnt;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   trial;

  assign trial = {rem, quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!run) begin
        if (start) begin
          run      <= 1'b1;
          cnt      <= '0;
          rem      <= '0;
          dvs      <= divisor;
          quotient <= dividend;
        end
      end else begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= CNT_W'(trial - {1'b0, dvs});
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem      <= trial[CNT_W-1:0];
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/smle_log.sv
// ----------------------------------------------------------------------------
// smle_log
// log2 sequencer: normalizing shift, then repeated squaring on the shared
// multiplier, result in signed q.32
// ----------------------------------------------------------------------------
module smle_log (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [63:0]                      x,
  input  logic [smle_pkg::FB_W-1:0]        fbits,
  output smle_pkg::mul_req_t               req,
  input  logic [63:0]                      prod,
  output logic                             done,
  output logic signed [smle_pkg::LOG_W-1:0] result
);
  import smle_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_MUL, L_SQR, L_FIN} lstate_t;

  lstate_t         state;
  logic [63:0]     xr;
  logic [5:0]      p;
  logic [FB_W-1:0] fb;
  logic [31:0]     m;
  logic [31:0]     frac;
  logic [IT_W-1:0] it;
  logic [32:0]     sq;
  logic [4:0]      fidx;
  logic [6:0]      pe;

  assign req  = '{a: m, b: m};
  assign sq   = prod[63:31];
  assign fidx = 5'(31 - 32'(it));
  assign pe   = {1'b0, p} - {1'b0, fb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            xr    <= x;
            p     <= 6'd63;
            fb    <= fbits;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (xr[63]) begin
            m     <= xr[63:32];
            frac  <= '0;
            it    <= '0;
            state <= L_MUL;
          end else begin
            xr <= {xr[62:0], 1'b0};
            p  <= p - 6'd1;
          end
        end
        L_MUL: state <= L_SQR;
        L_SQR: begin
          if (sq[32]) begin
            m <= sq[32:1];
            if (32'(it) < 32) frac[fidx] <= 1'b1;
          end else begin
            m <= sq[31:0];
          end
          it <= it + IT_W'(1);
          if (32'(it) + 1 == LOG_ITERATIONS) state <= L_FIN;
          else state <= L_MUL;
        end
        L_FIN: begin
          result <= {pe, frac};
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sample_moment_lognormal_estimator_unit.sv
// ----------------------------------------------------------------------------
// sample_moment_lognormal_estimator_unit
// accumulates q16.16 samples and on the last word of a set gives mean,
// variance and lognormal moment estimates
// ----------------------------------------------------------------------------
// a sample word runs S_SQX, S_SQD, S_ACCD (squares on the shared multiplier)
// a last word adds a mean divide, a variance divide if count > 1, and, if
// log_ok, three log2 runs and scaling before the one-cycle done strobe
// busy is high during all of it; results are not held back by the receiver
// synchronous reset clears all accumulators and the sequencer
module sample_moment_lognormal_estimator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] center,
  input  logic               last,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] mean_out,
  output logic [62:0]        variance_out,
  output logic signed [31:0] log_mu,
  output logic signed [31:0] log_sigma_sq,
  output logic               var_valid,
  output logic               log_valid,
  output logic               overflow
);
  import smle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQD, S_ACCD, S_DIVM, S_DIVMW, S_DIVV, S_DIVVW,
    S_LOGS, S_LOGSW, S_LOGQ, S_LOGQW, S_LOGN, S_LOGNW, S_COMB,
    S_MUHI, S_MULO, S_MUFIN, S_SGHI, S_SGLO, S_SGFIN, S_EMIT
  } state_t;

  state_t                   state;
  logic signed [31:0]       x_r, c_r;
  logic                     last_r;
  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  rsum;
  logic [63:0]              sqsum, dsum;
  logic                     sat;
  logic signed [LOG_W-1:0]  ls, lq;
  logic signed [T_W-1:0]    mu_t, sg_t;
  logic [44:0]              prod_hi;

  mul_req_t                 req, log_req;
  logic [63:0]              prod;
  logic                     div_start, div_done;
  logic [63:0]              dividend, quotient;
  logic [CNT_W-1:0]         divisor;
  logic                     log_start, log_done;
  logic                     log_ok;
  logic [63:0]              log_x;
  logic [FB_W-1:0]          log_fb;
  logic signed [LOG_W-1:0]  log_res;

  logic [32:0]              dx;
  logic [31:0]              ax, ad;
  logic [64:0]              add_sq;
  logic signed [SUM_W:0]    s_next;
  logic [SUM_W-1:0]         rmag;
  logic signed [T_W-1:0]    t_sel, ls_x, lq_x, ln_x;
  logic [T_W-1:0]           tmag;
  logic [45:0]              total, rnd;
  logic [45:0]              r;
  logic signed [31:0]       scaled;

  assign busy = (state != S_IDLE);

  assign dx = 33'(signed'(x_r)) - 33'(signed'(c_r));
  assign ax = x_r[31] ? 32'(-33'(signed'(x_r))) : 32'(x_r);
  assign ad = dx[32] ? 32'(-dx) : dx[31:0];
  assign add_sq = {1'b0, sqsum} + {1'b0, prod};
  assign s_next = (SUM_W+1)'(rsum) + (SUM_W+1)'(x_r);
  assign rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);

  assign ls_x = T_W'(ls);
  assign lq_x = T_W'(lq);
  assign ln_x = T_W'(log_res);

  always_comb begin
    unique case (state)
      S_MUHI, S_MULO, S_MUFIN: t_sel = mu_t;
      default:                 t_sel = sg_t;
    endcase
  end
  assign tmag  = t_sel[T_W-1] ? T_W'(-t_sel) : T_W'(t_sel);
  assign total = 46'(prod_hi) + 46'(prod[63:32]);
  assign rnd   = (state == S_MUFIN) ? (total + 46'h10000) >> 17 : (total + 46'h8000) >> 16;

  always_comb begin
    r = rnd;
    if (t_sel[T_W-1]) begin
      if (r > 46'h80000000) scaled = 32'sh80000000;
      else scaled = 32'(-r);
    end else begin
      if (r > 46'h7FFFFFFF) scaled = 32'sh7FFFFFFF;
      else scaled = 32'(r);
    end
  end

  always_comb begin
    unique case (state)
      S_SQX:          req = '{a: ax, b: ax};
      S_SQD:          req = '{a: ad, b: ad};
      S_MUHI, S_SGHI: req = '{a: {20'b0, tmag[T_W-1:32]}, b: LN2_Q32};
      S_MULO, S_SGLO: req = '{a: tmag[31:0], b: LN2_Q32};
      default:        req = log_req;
    endcase
  end

  assign div_start = (state == S_DIVM) || (state == S_DIVV);
  assign dividend  = (state == S_DIVM) ? 64'(rmag) : dsum;
  assign divisor   = (state == S_DIVM) ? count : count - CNT_W'(1);

  // logs only run for a positive sum and a nonzero sum of squares
  assign log_ok    = !rsum[SUM_W-1] && rsum != '0 && sqsum != '0;
  assign log_start = ((state == S_LOGS) && log_ok) || (state == S_LOGQ) ||
                     (state == S_LOGN);
  always_comb begin
    unique case (state)
      S_LOGS, S_LOGSW: begin log_x = 64'(rmag);  log_fb = FB_SUM;   end
      S_LOGQ, S_LOGQW: begin log_x = sqsum;      log_fb = FB_SQ;    end
      default:         begin log_x = 64'(count); log_fb = FB_COUNT; end
    endcase
  end

  smle_mul u_mul (.clk(clk), .req(req), .prod(prod));

  smle_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(divisor), .done(div_done), .quotient(quotient)
  );

  smle_log u_log (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x), .fbits(log_fb),
    .req(log_req), .prod(prod), .done(log_done), .result(log_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      rsum  <= '0;
      sqsum <= '0;
      dsum  <= '0;
      sat   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x_r    <= sample;
            c_r    <= center;
            last_r <= last;
            if (count >= CNT_W'(MAX_SAMPLES)) begin
              sat   <= 1'b1;
              state <= last ? S_DIVM : S_IDLE;
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQD;
        S_SQD: begin
          if (add_sq[64]) begin
            sqsum <= '1;
            sat   <= 1'b1;
          end else begin
            sqsum <= add_sq[63:0];
          end
          if (s_next > (SUM_W+1)'(signed'({1'b0, {(SUM_W-1){1'b1}}}))) begin
            rsum <= {1'b0, {(SUM_W-1){1'b1}}};
            sat  <= 1'b1;
          end else if (s_next < (SUM_W+1)'(signed'({1'b1, {(SUM_W-1){1'b0}}}))) begin
            rsum <= {1'b1, {(SUM_W-1){1'b0}}};
            sat  <= 1'b1;
          end else begin
            rsum <= SUM_W'(s_next);
          end
          count <= count + CNT_W'(1);
          state <= S_ACCD;
        end
        S_ACCD: begin
          if ({1'b0, dsum} + {1'b0, prod} > 65'h0FFFFFFFFFFFFFFFF) begin
            dsum <= '1;
            sat  <= 1'b1;
          end else begin
            dsum <= dsum + prod;
          end
          state <= last_r ? S_DIVM : S_IDLE;
        end
        S_DIVM: state <= S_DIVMW;
        S_DIVMW: begin
          if (div_done) begin
            if (rsum[SUM_W-1]) begin
              if (quotient > 64'h80000000) mean_out <= 32'sh80000000;
              else mean_out <= 32'(-quotient);
            end else begin
              if (quotient > 64'h7FFFFFFF) mean_out <= 32'sh7FFFFFFF;
              else mean_out <= 32'(quotient);
            end
            if (count > CNT_W'(1)) begin
              var_valid <= 1'b1;
              state     <= S_DIVV;
            end else begin
              var_valid    <= 1'b0;
              variance_out <= '0;
              state        <= S_LOGS;
            end
          end
        end
        S_DIVV: state <= S_DIVVW;
        S_DIVVW: begin
          if (div_done) begin
            variance_out <= 63'(quotient >> 16);
            state        <= S_LOGS;
          end
        end
        S_LOGS: begin
          if (log_ok) begin
            log_valid <= 1'b1;
            state     <= S_LOGSW;
          end else begin
            log_valid    <= 1'b0;
            log_mu       <= '0;
            log_sigma_sq <= '0;
            state        <= S_EMIT;
          end
        end
        S_LOGSW: if (log_done) begin ls <= log_res; state <= S_LOGQ; end
        S_LOGQ:  state <= S_LOGQW;
        S_LOGQW: if (log_done) begin lq <= log_res; state <= S_LOGN; end
        S_LOGN:  state <= S_LOGNW;
        S_LOGNW: if (log_done) state <= S_COMB;
        S_COMB: begin
          mu_t  <= (ls_x <<< 2) - lq_x - ln_x - (ln_x <<< 1);
          sg_t  <= lq_x - (ls_x <<< 1) + ln_x;
          state <= S_MUHI;
        end
        S_MUHI: state <= S_MULO;
        S_MULO: begin prod_hi <= 45'(prod); state <= S_MUFIN; end
        S_MUFIN: begin log_mu <= scaled; state <= S_SGHI; end
        S_SGHI: state <= S_SGLO;
        S_SGLO: begin prod_hi <= 45'(prod); state <= S_SGFIN; end
        S_SGFIN: begin log_sigma_sq <= scaled; state <= S_EMIT; end
        S_EMIT: begin
          done     <= 1'b1;
          overflow <= sat;
          count    <= '0;
          rsum     <= '0;
          sqsum    <= '0;
          dsum     <= '0;
          sat      <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
